// ===== src/sfcc_pkg.sv =====
// ============================================================================
// sfcc_pkg
// Shared types and constants for the sensor frame CRC check and convert block.
// ============================================================================
`default_nettype none

package sfcc_pkg;

    // Input item: one received byte or a bus failure notice
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in;

    // Result item
    typedef struct packed {
        logic signed [15:0] temp_centi;
        logic [1:0]         status;
    } t_out;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BUS_ERR = 2'd1;
    localparam logic [1:0] STAT_CRC_ERR = 2'd2;

    // Work handed from front to back
    typedef enum logic [1:0] {
        KIND_OK,
        KIND_BUS_ERR,
        KIND_CRC_ERR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] raw;
    } t_cmd;

    // Command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Conversion: ((TEMP_SCALE * raw) >> TEMP_SHIFT) - TEMP_OFFSET
    localparam int                 SCALE_W     = 13;
    localparam logic [SCALE_W-1:0] TEMP_SCALE  = 13'd4375;
    localparam int                 TEMP_SHIFT  = 14;
    localparam int                 PROD_W      = SCALE_W + 16;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
    localparam logic signed [15:0] ERR_TEMP    = -16'sd30000;

endpackage

`default_nettype wire

// ===== src/sfcc_front.sv =====
// ============================================================================
// sfcc_front
// Tracks frame position, runs the CRC-8 checks and issues one command per frame or bus failure.
// ============================================================================
`default_nettype none

module sfcc_front
    import sfcc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_in  i_data,
    input  wire logic i_q_full,
    output logic      o_ready,
    output logic      o_push,
    output t_cmd      o_cmd
);

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;

    function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

    logic [2:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_crc_acc,    n_crc_acc;
    logic [15:0] r_temp_raw,   n_temp_raw;
    logic        r_crc_bad,    n_crc_bad;
    logic        w_accept;
    logic        w_mismatch;

    assign o_ready    = !i_q_full;
    assign w_accept   = i_valid && o_ready;
    assign w_mismatch = (r_crc_acc != i_data.rx_byte);

    always_comb begin
        n_byte_count = r_byte_count;
        n_crc_acc    = r_crc_acc;
        n_temp_raw   = r_temp_raw;
        n_crc_bad    = r_crc_bad;
        o_push       = 1'b0;
        o_cmd.kind   = KIND_OK;
        o_cmd.raw    = r_temp_raw;
        if (w_accept) begin
            if (i_data.mode) begin
                o_push       = 1'b1;
                o_cmd.kind   = KIND_BUS_ERR;
                n_byte_count = POS_T_MSB;
                n_crc_acc    = CRC_INIT;
                n_crc_bad    = 1'b0;
            end else begin
                case (r_byte_count)
                    POS_T_MSB: begin
                        n_temp_raw   = {i_data.rx_byte, 8'h00};
                        n_crc_acc    = crc_byte(r_crc_acc, i_data.rx_byte);
                        n_byte_count = POS_T_LSB;
                    end
                    POS_T_LSB: begin
                        n_temp_raw   = {r_temp_raw[15:8], i_data.rx_byte};
                        n_crc_acc    = crc_byte(r_crc_acc, i_data.rx_byte);
                        n_byte_count = POS_T_CRC;
                    end
                    POS_T_CRC: begin
                        n_crc_bad    = r_crc_bad || w_mismatch;
                        n_crc_acc    = CRC_INIT;
                        n_byte_count = POS_H_MSB;
                    end
                    POS_H_MSB, POS_H_LSB: begin
                        n_crc_acc    = crc_byte(r_crc_acc, i_data.rx_byte);
                        n_byte_count = r_byte_count + 3'd1;
                    end
                    default: begin
                        // last byte of the frame (and any out-of-range position)
                        o_push       = 1'b1;
                        o_cmd.kind   = (r_crc_bad || w_mismatch) ? KIND_CRC_ERR : KIND_OK;
                        n_byte_count = POS_T_MSB;
                        n_crc_acc    = CRC_INIT;
                        n_crc_bad    = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= POS_T_MSB;
            r_crc_acc    <= CRC_INIT;
            r_temp_raw   <= 16'h0000;
            r_crc_bad    <= 1'b0;
        end else begin
            r_byte_count <= n_byte_count;
            r_crc_acc    <= n_crc_acc;
            r_temp_raw   <= n_temp_raw;
            r_crc_bad    <= n_crc_bad;
        end
    end

    a_bus_err_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.mode) |=> (r_byte_count == POS_T_MSB && !r_crc_bad))
        else $error("frame not restarted after bus failure");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= 3'd5)
        else $error("frame position out of range");

endmodule

`default_nettype wire

// ===== src/sfcc_queue.sv =====
// ============================================================================
// sfcc_queue
// Short command queue that decouples the checker front from the converter back.
// ============================================================================
`default_nettype none

module sfcc_queue
    import sfcc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("command pushed into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count overflow");

endmodule

`default_nettype wire

// ===== src/sfcc_back.sv =====
// ============================================================================
// sfcc_back
// Converts commands to result items: multiply stage, then offset and output.
// ============================================================================
`default_nettype none

module sfcc_back
    import sfcc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_cmd i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    logic              r_s1_valid;
    t_kind             r_s1_kind;
    logic [PROD_W-1:0] r_s1_prod;
    logic              r_out_valid;
    t_out              r_out;
    t_out              n_out;
    logic              w_out_load;
    logic              w_s1_load;

    assign w_out_load = !r_out_valid || i_ready;
    assign w_s1_load  = !r_s1_valid || w_out_load;
    assign o_pop      = w_s1_load && !i_q_empty;

    always_comb begin
        n_out.temp_centi = ERR_TEMP;
        n_out.status     = STAT_OK;
        case (r_s1_kind)
            KIND_OK: begin
                n_out.temp_centi = signed'({1'b0, r_s1_prod[PROD_W-1:TEMP_SHIFT]}) - TEMP_OFFSET;
            end
            KIND_BUS_ERR: n_out.status = STAT_BUS_ERR;
            KIND_CRC_ERR: n_out.status = STAT_CRC_ERR;
            default:      n_out.status = STAT_CRC_ERR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_kind <= i_cmd.kind;
            r_s1_prod <= PROD_W'(TEMP_SCALE) * PROD_W'(i_cmd.raw);
        end
        if (w_out_load && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= !i_q_empty;
            end
            if (w_out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == STAT_OK) |->
            (o_data.temp_centi >= -16'sd4500 && o_data.temp_centi <= 16'sd12999))
        else $error("converted temperature out of range");

endmodule

`default_nettype wire

// ===== src/sensor_frame_crc_check_convert.sv =====
// ============================================================================
// sensor_frame_crc_check_convert
// Checks the two CRC-8 bytes of a six-byte sensor frame and converts the
// temperature word to hundredths of a degree.
// ============================================================================
//
//  Channel | Ports                           | Item
//  --------+---------------------------------+--------------------------------
//  in      | i_valid, o_ready, i_data (t_in) | one frame byte or a bus failure
//  out     | o_valid, i_ready, o_data (t_out)| temperature and status
//
//  One input item per cycle while o_ready is high; the CRC update is an unrolled 8-bit step.
//  A result passes through the queue write, the multiply stage and the
//  offset/output stage before it leaves the output register.
//  o_ready drops only when the 2-entry command queue is full, i.e. when the
//  output side has stalled long enough to back up both converter stages.
//  Synchronous active-low reset restarts the frame; no results are pending.
// ============================================================================
`default_nettype none

module sensor_frame_crc_check_convert
    import sfcc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    // front -> queue
    logic w_push;
    t_cmd w_push_cmd;
    // queue -> back
    logic w_q_full;
    logic w_q_empty;
    logic w_pop;
    t_cmd w_pop_cmd;

    // Frame tracking and CRC checks; one command per finished frame or bus failure
    sfcc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_q_full (w_q_full),
        .o_ready  (o_ready),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    // Decouples front from back so each side stalls on its own
    sfcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_cmd   (w_pop_cmd)
    );

    // Scale, shift and offset; errors map to the fixed error temperature
    sfcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_cmd     (w_pop_cmd),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

`default_nettype wire

// ===== tb/tb_sensor_frame_crc_check_convert.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_sensor_frame_crc_check_convert
// Self-checking bench for the sensor frame CRC check and convert block.
// A directed table covers reset state, raw-word extremes, a known-good CRC,
// mismatches and bus failures. Random frames follow, mostly well-formed with
// some corrupt CRCs, aborted frames and noise. Every item is run through a
// local frame model. Each result is compared in arrival order.
// ============================================================================

module tb_sensor_frame_crc_check_convert;
    import sfcc_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int                 RANDOM_ITEMS  = 900;
    localparam int                 LONG_HOLD     = 300;    // receiver hold-off, cycles
    localparam int                 DRAIN_CYCLES  = 20;     // settle time to catch stray results
    localparam logic [7:0]         CRC8_POLY     = 8'h31;
    localparam logic [7:0]         CRC8_SEED     = 8'hFF;
    localparam longint             TEMP_GAIN     = 4375;
    localparam int                 TEMP_FRAC     = 14;
    localparam longint             TEMP_BIAS     = 4500;
    localparam logic signed [15:0] TEMP_ON_ERROR = -16'sd30000;

    // Where a frame byte comes from: literal value, the running CRC,
    // or the running CRC corrupted by a nonzero mask (val)
    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_CRC,
        SRC_BADCRC
    } t_src;

    typedef struct packed {
        logic               mode;
        logic [7:0]         val;
        t_src               src;
        logic               pinned;     // expected result typed in below
        logic signed [15:0] exp_temp;
        logic [1:0]         exp_stat;
    } t_stim_row;

    localparam int DIR_ROWS = 22;

    // Directed stimulus. Pinned rows carry a result that is obvious by hand.
    t_stim_row stim_table [DIR_ROWS] = '{
        // bus failure straight out of reset; rx_byte must be ignored
        '{1'b1, 8'hFF, SRC_LIT,    1'b1, TEMP_ON_ERROR, STAT_BUS_ERR},
        // raw word 0x0000 -> lowest reading
        '{1'b0, 8'h00, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'h00, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'h00, SRC_CRC,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'h00, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'h00, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'h00, SRC_CRC,    1'b1, -16'sd4500,    STAT_OK},
        // raw word 0xFFFF -> highest reading
        '{1'b0, 8'hFF, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'hFF, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'h00, SRC_CRC,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'hFF, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'hFF, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'h00, SRC_CRC,    1'b1, 16'sd12999,    STAT_OK},
        // 0xBEEF has the textbook CRC 0x92; humidity CRC is then corrupted
        '{1'b0, 8'hBE, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'hEF, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'h92, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'h00, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'h00, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'h01, SRC_BADCRC, 1'b1, TEMP_ON_ERROR, STAT_CRC_ERR},
        // bus failure in mid-frame aborts it
        '{1'b0, 8'hAB, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b0, 8'hCD, SRC_LIT,    1'b0, 16'sd0,        STAT_OK},
        '{1'b1, 8'h00, SRC_LIT,    1'b1, TEMP_ON_ERROR, STAT_BUS_ERR}
    };

    // ------------------------------------------------------------------------
    // DUT hookup; every input known from time 0
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_data  = '0;
    logic i_ready = 1'b0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    sensor_frame_crc_check_convert u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Frame model: mirrors the block's frame state
    // ------------------------------------------------------------------------
    logic [2:0]  frm_pos;
    logic [7:0]  crc_run;
    logic [15:0] temp_word;
    logic        crc_fail;

    t_out pending_readings [$];   // expected results, oldest first
    int   mismatch_count = 0;
    int   items_sent     = 0;
    int   readings_seen  = 0;
    bit   tx_burst       = 1'b0;  // sender: no gaps while set
    bit   rx_burst       = 1'b0;  // receiver: no stalls while set

    function automatic logic [7:0] crc8_update(logic [7:0] acc, logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int i = 0; i < 8; i++)
            c = c[7] ? ((c << 1) ^ CRC8_POLY) : (c << 1);
        return c;
    endfunction

    function automatic void frame_restart();
        frm_pos  = 3'd0;
        crc_run  = CRC8_SEED;
        crc_fail = 1'b0;
    endfunction

    // One accepted item in, zero or one reading out
    function automatic void predict_reading(input t_in it, output bit has_res,
                                            output t_out res);
        longint scaled;
        has_res = 1'b0;
        res     = '0;
        if (it.mode) begin
            has_res        = 1'b1;
            res.temp_centi = TEMP_ON_ERROR;
            res.status     = STAT_BUS_ERR;
            frame_restart();
        end else begin
            case (frm_pos)
                3'd0: begin
                    temp_word = {it.rx_byte, 8'h00};
                    crc_run   = crc8_update(crc_run, it.rx_byte);
                    frm_pos   = 3'd1;
                end
                3'd1: begin
                    temp_word[7:0] = it.rx_byte;
                    crc_run        = crc8_update(crc_run, it.rx_byte);
                    frm_pos        = 3'd2;
                end
                3'd2: begin
                    if (crc_run != it.rx_byte)
                        crc_fail = 1'b1;
                    crc_run = CRC8_SEED;
                    frm_pos = 3'd3;
                end
                3'd3, 3'd4: begin
                    crc_run = crc8_update(crc_run, it.rx_byte);
                    frm_pos = frm_pos + 3'd1;
                end
                default: begin
                    // sixth byte closes the frame
                    if (crc_run != it.rx_byte)
                        crc_fail = 1'b1;
                    has_res = 1'b1;
                    if (crc_fail) begin
                        res.temp_centi = TEMP_ON_ERROR;
                        res.status     = STAT_CRC_ERR;
                    end else begin
                        scaled         = ((longint'(temp_word) * TEMP_GAIN) >> TEMP_FRAC)
                                         - TEMP_BIAS;
                        res.temp_centi = 16'(scaled);
                        res.status     = STAT_OK;
                    end
                    frame_restart();
                end
            endcase
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Sender: random gap, offer item, hold it until o_ready, then predict.
    // o_ready/o_valid are sampled at the falling edge, clear of the rising
    // edge where the DUT updates.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic mode, input logic [7:0] val, input t_src src,
                             input bit pinned, input t_out pinned_res);
        t_in  it;
        int   gap;
        bit   has_res;
        t_out res;
        it.mode = mode;
        case (src)
            SRC_CRC:    it.rx_byte = crc_run;
            SRC_BADCRC: it.rx_byte = crc_run ^ val;
            default:    it.rx_byte = val;
        endcase
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 19) == 0)
            tx_burst = !tx_burst;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);                       // item taken here
        items_sent++;
        predict_reading(it, has_res, res);
        if (has_res)
            pending_readings.push_back(pinned ? pinned_res : res);
    endtask

    // ------------------------------------------------------------------------
    // Reset and stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_out       pin_res;
        t_out       no_pin;
        t_src       src;
        logic [7:0] val;
        logic [15:0] tw;
        logic [15:0] hw;
        bit         aborted;
        int         r;

        no_pin = '0;
        frame_restart();
        temp_word = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (stim_table[k]) begin
            pin_res.temp_centi = stim_table[k].exp_temp;
            pin_res.status     = stim_table[k].exp_stat;
            send_item(stim_table[k].mode, stim_table[k].val, stim_table[k].src,
                      stim_table[k].pinned, pin_res);
        end

        // Random part: mostly whole frames, some noise and bus-failure bursts
        while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                // Whole frame, CRC sometimes corrupted or cut short; extremes of the raw word now and then
                if ($urandom_range(0, 9) == 0)
                    tw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                else
                    tw = 16'($urandom);
                hw      = 16'($urandom);
                aborted = 1'b0;
                for (int k = 0; k < 6 && !aborted; k++) begin
                    if ($urandom_range(0, 99) < 3) begin
                        // bus failure cuts the frame short
                        send_item(1'b1, 8'($urandom), SRC_LIT, 1'b0, no_pin);
                        aborted = 1'b1;
                    end else begin
                        src = SRC_LIT;
                        case (k)
                            0:       val = tw[15:8];
                            1:       val = tw[7:0];
                            3:       val = hw[15:8];
                            4:       val = hw[7:0];
                            default: begin
                                // CRC slot; roughly one in ten corrupted
                                if ($urandom_range(0, 9) == 0) begin
                                    src = SRC_BADCRC;
                                    val = 8'($urandom_range(1, 255));
                                end else begin
                                    src = SRC_CRC;
                                    val = 8'h00;
                                end
                            end
                        endcase
                        send_item(1'b0, val, src, 1'b0, no_pin);
                    end
                end
            end else if (r < 90) begin
                // Noise: arbitrary items, usually followed by a realigning failure
                repeat ($urandom_range(1, 8))
                    send_item($urandom_range(0, 9) == 0, 8'($urandom), SRC_LIT,
                              1'b0, no_pin);
                if ($urandom_range(0, 3) != 0)
                    send_item(1'b1, 8'($urandom), SRC_LIT, 1'b0, no_pin);
            end else begin
                // Back-to-back bus failures: a result per item
                repeat ($urandom_range(1, 4))
                    send_item(1'b1, 8'($urandom), SRC_LIT, 1'b0, no_pin);
            end
        end
        i_valid <= 1'b0;

        // Drain, then let the pipeline settle to catch stray results
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, two long hold-offs to back up the block
    // ------------------------------------------------------------------------
    initial begin
        t_out got;
        t_out exp;
        int   stall;

        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (readings_seen == 40 || readings_seen == 110)
                stall = LONG_HOLD;
            else
                stall = rx_burst ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0)
                rx_burst = !rx_burst;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(negedge i_clk);
            while (!o_valid) @(negedge i_clk);
            got = o_data;
            @(posedge i_clk);                   // result taken here
            readings_seen++;
            if (pending_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected result temp=%0d status=%0d",
                                          got.temp_centi, got.status));
            end else begin
                exp = pending_readings.pop_front();
                if (got.temp_centi !== exp.temp_centi)
                    report_mismatch($sformatf("temp_centi got %0d exp %0d",
                                              got.temp_centi, exp.temp_centi));
                if (got.status !== exp.status)
                    report_mismatch($sformatf("status got %0d exp %0d",
                                              got.status, exp.status));
            end
        end
    end

endmodule

// ===== sensor_frame_crc_check_convert.f =====
src/sfcc_pkg.sv
src/sfcc_front.sv
src/sfcc_queue.sv
src/sfcc_back.sv
src/sensor_frame_crc_check_convert.sv
tb/tb_sensor_frame_crc_check_convert.sv
